FILE: hw/rtl/qph_pkg.sv
// Shared types and constants for the quadratic-probe hash table.
// No dependencies; qph_mod, qph_store and the top level import this package.
package qph_pkg;

	localparam int KEY_W = 32;
	localparam int VAL_W = 32;
	localparam int LEN_W = 11;

	typedef enum logic [1:0] {
		REQ_INSERT = 2'd0,
		REQ_SEARCH = 2'd1,
		REQ_DELETE = 2'd2,
		REQ_NONE   = 2'd3
	} req_type_t;

	typedef enum logic [1:0] {
		STS_OK        = 2'd0,
		STS_NOT_FOUND = 2'd1,
		STS_FULL      = 2'd2,
		STS_RSVD      = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		MARK_EMPTY = 2'd0,
		MARK_USED  = 2'd1,
		MARK_TOMB  = 2'd2,
		MARK_RSVD  = 2'd3
	} mark_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_HASH,
		ST_READ,
		ST_CHECK,
		ST_DONE
	} state_t;

	// One slot of the table store.
	typedef struct packed {
		mark_t              mark;
		logic [KEY_W-1:0]   key;
		logic [VAL_W-1:0]   payload;
	} slot_row_t;

	// Handshake between the sequencer and the remainder unit.
	typedef struct packed {
		logic start;
		logic done;
	} mod_ctl_t;

endpackage

FILE: hw/rtl/qph_if.sv
// Channel interfaces: request, response and configuration write.
// No dependencies.
interface qph_req_if;
	logic                  valid;
	logic                  ready;
	logic [1:0]            req_type;
	logic [31:0]           key;
	logic [31:0]           value;
	modport source (output valid, req_type, key, value, input ready);
	modport sink   (input valid, req_type, key, value, output ready);
endinterface

interface qph_rsp_if;
	logic                  valid;
	logic                  ready;
	logic [1:0]            status;
	logic [31:0]           found_value;
	logic [10:0]           probe_count;
	logic [10:0]           occupancy;
	modport source (output valid, status, found_value, probe_count, occupancy, input ready);
	modport sink   (input valid, status, found_value, probe_count, occupancy, output ready);
endinterface

interface qph_cfg_if;
	logic                  valid;
	logic                  ready;
	logic [10:0]           table_len;
	modport source (output valid, table_len, input ready);
	modport sink   (input valid, table_len, output ready);
endinterface

FILE: hw/rtl/qph_mod.sv
// Iterative remainder unit: 32-bit dividend mod an 11-bit divisor,
// two restoring steps per cycle. Depends on qph_pkg.
module qph_mod (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	input  logic [31:0]             dividend,
	input  logic [10:0]             divisor,
	output logic                    done,
	output logic [10:0]             rem
);
	import qph_pkg::*;

	localparam int STEPS = KEY_W / 2;
	localparam int CW    = $clog2(STEPS);

	logic [KEY_W-1:0] sh_q;
	logic [LEN_W-1:0] rem_q;
	logic [CW-1:0]    cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [LEN_W:0]   t1;
	logic [LEN_W:0]   t2;
	logic [LEN_W-1:0] r1;

	// Two steps: shift in one bit, subtract divisor if it fits; then again with the next bit.
	always_comb begin
		t1 = {rem_q, sh_q[KEY_W-1]};
		if (t1 >= {1'b0, divisor}) t1 = t1 - {1'b0, divisor};
		r1 = t1[LEN_W-1:0];
		t2 = {r1, sh_q[KEY_W-2]};
		if (t2 >= {1'b0, divisor}) t2 = t2 - {1'b0, divisor};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CW'(STEPS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			sh_q  <= dividend;
			rem_q <= '0;
		end else if (busy_q) begin
			sh_q  <= {sh_q[KEY_W-3:0], 2'b00};
			rem_q <= t2[LEN_W-1:0];
		end
	end

	assign done = done_q;
	assign rem  = rem_q;
endmodule

FILE: hw/rtl/qph_store.sv
// Slot store: one write port, one read port with registered read data.
// Depends on qph_pkg.
module qph_store #(
	parameter int DEPTH = 1024,
	parameter int AW    = 10
) (
	input  logic                clk,
	input  logic                we,
	input  logic [AW-1:0]       waddr,
	input  qph_pkg::slot_row_t  wdata,
	input  logic [AW-1:0]       raddr,
	output qph_pkg::slot_row_t  rdata
);
	import qph_pkg::*;

	slot_row_t mem_q [DEPTH];
	slot_row_t rdata_q;

	always_ff @(posedge clk) begin
		if (we) mem_q[waddr] <= wdata;
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;
endmodule

FILE: hw/rtl/quadratic_probe_hash_table.sv
// Top level of the quadratic-probe hash table: sequencer, config register,
// response register. Depends on qph_pkg, qph_if, qph_mod and qph_store.
//
// Usage:
//   cfg  - write channel for table_len (slot count used for hashing and
//          probing). 0 acts as 1, values above CAPACITY act as CAPACITY.
//          Always ready; write only while no request is in flight.
//   req  - one request per handshake: insert, search or delete of key/value.
//          Ready only while the sequencer is idle.
//   rsp  - one response per request: status, found_value, probe_count and
//          occupancy after the request.
// Flow: the remainder unit first computes the home slot, retiring two key bits
//   per cycle; each probe is then a store read followed by compare/update.
//   Requests with type 3 go straight to the done state without touching the table.
// Reset: the store is swept to empty, one slot per cycle, over all CAPACITY
//   slots; req stays not ready meanwhile, cfg writes are taken as usual.
// Stall: a finished response sits in the response register; the next request
//   is taken and worked on, and it waits in the done state only if the
//   previous response has still not been taken.
module quadratic_probe_hash_table #(
	parameter int CAPACITY = 1024,
	parameter int KEY_BITS = 32
) (
	input  logic    clk,
	input  logic    arst_n,
	qph_cfg_if.sink cfg,
	qph_req_if.sink req,
	qph_rsp_if.source rsp
);
	import qph_pkg::*;

	localparam int AW      = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CAP_LIM = (CAPACITY > 2047) ? 2047 : CAPACITY;
	localparam int KB      = (KEY_BITS < KEY_W) ? KEY_BITS : KEY_W;
	localparam logic [KEY_W-1:0] KEY_MASK = {KEY_W{1'b1}} >> (KEY_W - KB);

	state_t state_q, state_n;

	logic [LEN_W-1:0] table_len_q;
	logic [LEN_W-1:0] len_eff;
	logic [LEN_W-1:0] len_q;
	req_type_t        op_q;
	logic [KEY_W-1:0] key_q;
	logic [VAL_W-1:0] val_q;
	logic [LEN_W-1:0] k_q;
	logic [LEN_W-1:0] slot_q;
	logic [LEN_W-1:0] step_q;
	logic [LEN_W-1:0] used_q;
	logic [AW-1:0]    clr_q;

	// Pending result, held until the response register is free.
	status_t          res_sts_q;
	logic [VAL_W-1:0] res_fv_q;
	logic [LEN_W-1:0] res_pc_q;

	// Response register.
	logic             rsp_vld_q;
	status_t          rsp_sts_q;
	logic [VAL_W-1:0] rsp_fv_q;
	logic [LEN_W-1:0] rsp_pc_q;
	logic [LEN_W-1:0] rsp_occ_q;

	mod_ctl_t         mod_ctl;
	logic [LEN_W-1:0] home;
	logic [KEY_W-1:0] mod_key;

	logic             mem_we;
	logic [AW-1:0]    mem_waddr;
	slot_row_t        mem_wdata;
	slot_row_t        rd;

	logic             req_acc;
	logic             rsp_free;
	logic             is_ins;
	logic             is_del;
	logic             hit_free;
	logic             hit_empty;
	logic             hit_match;
	logic             term;
	logic             last;
	logic [LEN_W-1:0] k_inc;
	logic [LEN_W:0]   slot_sum;
	logic [LEN_W-1:0] slot_nxt;
	logic [LEN_W:0]   step_sum;
	logic [LEN_W:0]   step_tmp;
	logic [LEN_W-1:0] step_nxt;
	logic [LEN_W-1:0] step_init;

	// Effective length: clamp to 1..CAPACITY.
	always_comb begin
		len_eff = table_len_q;
		if (table_len_q == '0) len_eff = LEN_W'(1);
		if (table_len_q > LEN_W'(CAP_LIM)) len_eff = LEN_W'(CAP_LIM);
	end

	assign cfg.ready = 1'b1;
	assign rsp_free  = !rsp_vld_q || rsp.ready;
	assign req_acc   = req.valid && req.ready;

	// The remainder unit loads its dividend on the accepting edge, before
	// key_q holds the new key, so feed it straight from the request.
	assign mod_key = (state_q == ST_IDLE) ? (req.key & KEY_MASK) : key_q;

	qph_mod u_mod (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (mod_ctl.start),
		.dividend (mod_key),
		.divisor  (len_q),
		.done     (mod_ctl.done),
		.rem      (home)
	);

	qph_store #(.DEPTH(CAPACITY), .AW(AW)) u_store (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.raddr (AW'(slot_q)),
		.rdata (rd)
	);

	// Probe decode on the slot just read.
	always_comb begin
		is_ins    = (op_q == REQ_INSERT);
		is_del    = (op_q == REQ_DELETE);
		hit_free  = (rd.mark != MARK_USED);
		hit_empty = (rd.mark == MARK_EMPTY);
		hit_match = (rd.mark == MARK_USED) && (rd.key == key_q);
		term      = is_ins ? hit_free : (hit_empty || hit_match);
		k_inc     = k_q + 1'b1;
		last      = (k_inc == len_q);
		// Next slot: slot + step, step = (2k+1) mod L, both below L.
		slot_sum  = {1'b0, slot_q} + {1'b0, step_q};
		if (slot_sum >= {1'b0, len_q}) slot_sum = slot_sum - {1'b0, len_q};
		slot_nxt  = slot_sum[LEN_W-1:0];
		// Next step: +2 mod L, which may wrap twice when L is 1.
		step_sum  = {1'b0, step_q} + (LEN_W+1)'(2);
		step_tmp  = step_sum;
		if (step_tmp >= {1'b0, len_q}) step_tmp = step_tmp - {1'b0, len_q};
		if (step_tmp >= {1'b0, len_q}) step_tmp = step_tmp - {1'b0, len_q};
		step_nxt  = step_tmp[LEN_W-1:0];
		step_init = (len_q == LEN_W'(1)) ? '0 : LEN_W'(1);
	end

	// Next state.
	always_comb begin
		state_n = state_q;
		unique case (state_q)
			ST_CLEAR: if (clr_q == AW'(CAPACITY - 1)) state_n = ST_IDLE;
			ST_IDLE: begin
				if (req_acc) begin
					state_n = (req_type_t'(req.req_type) == REQ_NONE) ? ST_DONE : ST_HASH;
				end
			end
			ST_HASH:  if (mod_ctl.done) state_n = ST_READ;
			ST_READ:  state_n = ST_CHECK;
			ST_CHECK: state_n = (term || last) ? ST_DONE : ST_READ;
			ST_DONE:  if (rsp_free) state_n = ST_IDLE;
			default:  state_n = ST_CLEAR;
		endcase
	end

	// Outputs of the sequencer.
	always_comb begin
		req.ready     = 1'b0;
		mod_ctl.start = 1'b0;
		mem_we        = 1'b0;
		mem_waddr     = AW'(slot_q);
		mem_wdata     = '{mark: MARK_USED, key: key_q, payload: val_q};
		unique case (state_q)
			ST_CLEAR: begin
				mem_we    = 1'b1;
				mem_waddr = clr_q;
				mem_wdata = '{mark: MARK_EMPTY, key: '0, payload: '0};
			end
			ST_IDLE: req.ready = 1'b1;
			ST_HASH: mod_ctl.start = 1'b0;
			ST_CHECK: begin
				if (is_ins && hit_free) begin
					mem_we = 1'b1;
				end else if (is_del && hit_match) begin
					mem_we    = 1'b1;
					mem_wdata = '{mark: MARK_TOMB, key: rd.key, payload: rd.payload};
				end
			end
			default: ;
		endcase
		// Kick the remainder unit as the request is taken.
		if (state_q == ST_IDLE && req_acc &&
		    req_type_t'(req.req_type) != REQ_NONE) mod_ctl.start = 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			table_len_q <= LEN_W'(1024);
			used_q      <= '0;
			clr_q       <= '0;
			rsp_vld_q   <= 1'b0;
		end else begin
			state_q <= state_n;
			if (cfg.valid) table_len_q <= cfg.table_len;
			if (state_q == ST_CLEAR) clr_q <= clr_q + 1'b1;
			if (state_q == ST_CHECK) begin
				if (is_ins && hit_free) used_q <= used_q + 1'b1;
				else if (is_del && hit_match && used_q != '0) used_q <= used_q - 1'b1;
			end
			if (state_q == ST_DONE && rsp_free) rsp_vld_q <= 1'b1;
			else if (rsp.ready) rsp_vld_q <= 1'b0;
		end
	end

	// Request latch, probe walk and result capture.
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && req_acc) begin
			op_q      <= req_type_t'(req.req_type);
			key_q     <= req.key & KEY_MASK;
			val_q     <= req.value;
			len_q     <= len_eff;
			res_sts_q <= STS_NOT_FOUND;
			res_fv_q  <= '0;
			res_pc_q  <= '0;
		end
		if (state_q == ST_HASH && mod_ctl.done) begin
			slot_q <= home;
			k_q    <= '0;
			step_q <= step_init;
		end
		if (state_q == ST_CHECK) begin
			if (term) begin
				res_pc_q <= k_q;
				if (is_ins) begin
					res_sts_q <= STS_OK;
					res_fv_q  <= '0;
				end else if (hit_match) begin
					res_sts_q <= STS_OK;
					res_fv_q  <= rd.payload;
				end else begin
					res_sts_q <= STS_NOT_FOUND;
					res_fv_q  <= '0;
				end
			end else if (last) begin
				res_pc_q  <= len_q;
				res_sts_q <= is_ins ? STS_FULL : STS_NOT_FOUND;
				res_fv_q  <= '0;
			end else begin
				k_q    <= k_inc;
				slot_q <= slot_nxt;
				step_q <= step_nxt;
			end
		end
		if (state_q == ST_DONE && rsp_free) begin
			rsp_sts_q <= res_sts_q;
			rsp_fv_q  <= res_fv_q;
			rsp_pc_q  <= res_pc_q;
			rsp_occ_q <= used_q;
		end
	end

	assign rsp.valid       = rsp_vld_q;
	assign rsp.status      = rsp_sts_q;
	assign rsp.found_value = rsp_fv_q;
	assign rsp.probe_count = rsp_pc_q;
	assign rsp.occupancy   = rsp_occ_q;

	// Probe index and slot stay inside the table during the walk.
	a_probe_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_READ || state_q == ST_CHECK) |-> (k_q < len_q && slot_q < len_q))
		else $error("probe index or slot beyond table length");

	// The store is written only by the clearing sweep or a probe decision.
	a_write_src: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> (state_q == ST_CLEAR || state_q == ST_CHECK))
		else $error("store write outside sweep or probe check");

	// No request is taken before the clearing sweep has finished.
	a_no_req_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CLEAR) |-> !req.ready)
		else $error("request taken during clearing sweep");
endmodule
